>>> sv/sgi_pkg.sv
package sgi_pkg;

    localparam int COORD_BITS_DEF = 16;

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MIRROR_START_X = 3'd0,
        CFG_MIRROR_START_Y = 3'd1,
        CFG_MIRROR_END_X   = 3'd2,
        CFG_MIRROR_END_Y   = 3'd3
    } sgi_cfg_idx_t;

    // per-stage control that travels with each request
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } sgi_ctl_t;

endpackage

>>> sv/segment_intersection_2d.sv
// Tests each ray segment against the mirror segment held in the four
// configuration registers and returns one result per ray: the hit flag and,
// on a hit, the intersection point mirror_start + (n2 * mirror) / d with the
// quotient truncated toward zero (zero coordinates when there is no hit;
// parallel or degenerate segments never hit). One ray is accepted every
// clock cycle while ray_stall is low. A ray passes through six arithmetic
// stages (differences, cross products, cross sums, hit test, split multiply,
// product sum), then one stage per quotient bit of the restoring divider,
// then the output register. A one-entry skid register behind the output
// absorbs the result that is still in flight when result_stall rises;
// ray_stall is high while it is occupied. Write the mirror only while no
// ray is in flight.
module segment_intersection_2d
    import sgi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data,

    input  logic                         ray_valid,
    output logic                         ray_stall,
    input  logic signed [COORD_BITS-1:0] ray_start_x,
    input  logic signed [COORD_BITS-1:0] ray_start_y,
    input  logic signed [COORD_BITS-1:0] ray_end_x,
    input  logic signed [COORD_BITS-1:0] ray_end_y,

    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         hit,
    output logic signed [COORD_BITS-1:0] hit_x,
    output logic signed [COORD_BITS-1:0] hit_y
);

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * COORD_BITS + 2;
    localparam int CW  = 2 * COORD_BITS + 3;
    localparam int MW  = 2 * COORD_BITS + 2;
    localparam int HW  = COORD_BITS + 1;
    localparam int PPW = HW + COORD_BITS;
    localparam int QW  = COORD_BITS;
    localparam int RW  = 3 * COORD_BITS + 2;

    // mirror registers
    logic signed [COORD_BITS-1:0] mirror_start_x_reg;
    logic signed [COORD_BITS-1:0] mirror_start_y_reg;
    logic signed [COORD_BITS-1:0] mirror_end_x_reg;
    logic signed [COORD_BITS-1:0] mirror_end_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_start_x_reg <= '0;
            mirror_start_y_reg <= '0;
            mirror_end_x_reg   <= '0;
            mirror_end_y_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIRROR_START_X: mirror_start_x_reg <= cfg_data;
                CFG_MIRROR_START_Y: mirror_start_y_reg <= cfg_data;
                CFG_MIRROR_END_X:   mirror_end_x_reg   <= cfg_data;
                CFG_MIRROR_END_Y:   mirror_end_y_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    logic en;
    logic skid_valid_reg;

    assign en        = !skid_valid_reg;
    assign ray_stall = skid_valid_reg;

    // mirror direction; the user keeps it constant while rays are in flight, the block does not enforce this
    logic signed [DW-1:0] mir_dx;
    logic signed [DW-1:0] mir_dy;
    logic signed [DW-1:0] mir_dx_pos;
    logic signed [DW-1:0] mir_dy_pos;

    assign mir_dx     = DW'(mirror_end_x_reg) - DW'(mirror_start_x_reg);
    assign mir_dy     = DW'(mirror_end_y_reg) - DW'(mirror_start_y_reg);
    assign mir_dx_pos = mir_dx[DW-1] ? -mir_dx : mir_dx;
    assign mir_dy_pos = mir_dy[DW-1] ? -mir_dy : mir_dy;

    // stage 1: differences
    sgi_ctl_t             s1_ctl_reg;
    logic signed [DW-1:0] s1_vx_reg, s1_vy_reg;
    logic signed [DW-1:0] s1_v1x_reg, s1_v1y_reg;
    logic signed [DW-1:0] s1_v2x_reg, s1_v2y_reg;

    // stage 2: products
    sgi_ctl_t             s2_ctl_reg;
    logic signed [PW-1:0] s2_d0_reg, s2_d1_reg;
    logic signed [PW-1:0] s2_a0_reg, s2_a1_reg;
    logic signed [PW-1:0] s2_b0_reg, s2_b1_reg;

    // stage 3: cross products
    sgi_ctl_t             s3_ctl_reg;
    logic signed [CW-1:0] s3_d_reg, s3_n1_reg, s3_n2_reg;

    // stage 4: hit test and magnitudes
    sgi_ctl_t      s4_ctl_reg;
    sgi_ctl_t      s4_ctl_next;
    logic [MW-1:0] s4_dabs_reg, s4_n2abs_reg;
    logic [QW-1:0] s4_v2x_abs_reg, s4_v2y_abs_reg;

    // stage 5: split products
    sgi_ctl_t       s5_ctl_reg;
    logic [MW-1:0]  s5_dabs_reg;
    logic [PPW-1:0] s5_plo_x_reg, s5_phi_x_reg;
    logic [PPW-1:0] s5_plo_y_reg, s5_phi_y_reg;

    // stage 6: dividends
    sgi_ctl_t      s6_ctl_reg;
    logic [MW-1:0] s6_dabs_reg;
    logic [RW-1:0] s6_prod_x_reg, s6_prod_y_reg;

    logic signed [CW-1:0] d_pos, n2_pos;
    logic                 d_neg, d_zero, n1_in, n2_in;

    assign d_neg  = s3_d_reg[CW-1];
    assign d_zero = (s3_d_reg == '0);
    assign d_pos  = d_neg ? -s3_d_reg : s3_d_reg;
    assign n2_pos = s3_n2_reg[CW-1] ? -s3_n2_reg : s3_n2_reg;

    // n/d within [0,1] by sign comparisons
    always_comb
    begin
        if (d_neg)
        begin
            n1_in = (s3_n1_reg[CW-1] || s3_n1_reg == '0) && (s3_n1_reg >= s3_d_reg);
            n2_in = (s3_n2_reg[CW-1] || s3_n2_reg == '0) && (s3_n2_reg >= s3_d_reg);
        end
        else
        begin
            n1_in = !s3_n1_reg[CW-1] && (s3_n1_reg <= s3_d_reg);
            n2_in = !s3_n2_reg[CW-1] && (s3_n2_reg <= s3_d_reg);
        end
        s4_ctl_next       = s3_ctl_reg;
        s4_ctl_next.hit   = !d_zero && n1_in && n2_in;
        s4_ctl_next.neg_x = mir_dx[DW-1];
        s4_ctl_next.neg_y = mir_dy[DW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
            s6_ctl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg <= '{valid: ray_valid, hit: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s4_ctl_next;
            s5_ctl_reg <= s4_ctl_reg;
            s6_ctl_reg <= s5_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_vx_reg  <= DW'(mirror_start_x_reg) - DW'(ray_start_x);
            s1_vy_reg  <= DW'(mirror_start_y_reg) - DW'(ray_start_y);
            s1_v1x_reg <= DW'(ray_end_x) - DW'(ray_start_x);
            s1_v1y_reg <= DW'(ray_end_y) - DW'(ray_start_y);
            s1_v2x_reg <= mir_dx;
            s1_v2y_reg <= mir_dy;

            s2_d0_reg <= PW'(s1_v1x_reg) * PW'(s1_v2y_reg);
            s2_d1_reg <= PW'(s1_v1y_reg) * PW'(s1_v2x_reg);
            s2_a0_reg <= PW'(s1_vx_reg) * PW'(s1_v2y_reg);
            s2_a1_reg <= PW'(s1_vy_reg) * PW'(s1_v2x_reg);
            s2_b0_reg <= PW'(s1_vx_reg) * PW'(s1_v1y_reg);
            s2_b1_reg <= PW'(s1_vy_reg) * PW'(s1_v1x_reg);

            s3_d_reg  <= CW'(s2_d0_reg) - CW'(s2_d1_reg);
            s3_n1_reg <= CW'(s2_a0_reg) - CW'(s2_a1_reg);
            s3_n2_reg <= CW'(s2_b0_reg) - CW'(s2_b1_reg);

            s4_dabs_reg    <= d_pos[MW-1:0];
            s4_n2abs_reg   <= n2_pos[MW-1:0];
            s4_v2x_abs_reg <= mir_dx_pos[QW-1:0];
            s4_v2y_abs_reg <= mir_dy_pos[QW-1:0];

            s5_dabs_reg  <= s4_dabs_reg;
            s5_plo_x_reg <= PPW'(s4_n2abs_reg[HW-1:0]) * PPW'(s4_v2x_abs_reg);
            s5_phi_x_reg <= PPW'(s4_n2abs_reg[MW-1:HW]) * PPW'(s4_v2x_abs_reg);
            s5_plo_y_reg <= PPW'(s4_n2abs_reg[HW-1:0]) * PPW'(s4_v2y_abs_reg);
            s5_phi_y_reg <= PPW'(s4_n2abs_reg[MW-1:HW]) * PPW'(s4_v2y_abs_reg);

            s6_dabs_reg   <= s5_dabs_reg;
            s6_prod_x_reg <= (RW'(s5_phi_x_reg) << HW) + RW'(s5_plo_x_reg);
            s6_prod_y_reg <= (RW'(s5_phi_y_reg) << HW) + RW'(s5_plo_y_reg);
        end
    end

    sgi_ctl_t      div_ctl;
    logic [QW-1:0] div_quo_x, div_quo_y;

    sgi_div_pipe #(
        .QUO_BITS     (QW),
        .DIVISOR_BITS (MW),
        .REM_BITS     (RW)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_ctl     (s6_ctl_reg),
        .divisor    (s6_dabs_reg),
        .dividend_x (s6_prod_x_reg),
        .dividend_y (s6_prod_y_reg),
        .out_ctl    (div_ctl),
        .quo_x      (div_quo_x),
        .quo_y      (div_quo_y)
    );

    // final point
    logic [QW-1:0]         off_x, off_y;
    logic [COORD_BITS-1:0] fin_x, fin_y;

    assign off_x = div_ctl.neg_x ? (~div_quo_x + QW'(1)) : div_quo_x;
    assign off_y = div_ctl.neg_y ? (~div_quo_y + QW'(1)) : div_quo_y;
    assign fin_x = div_ctl.hit ? (mirror_start_x_reg + off_x) : '0;
    assign fin_y = div_ctl.hit ? (mirror_start_y_reg + off_y) : '0;

    // output register with one skid entry
    logic                  res_valid_reg, res_valid_next;
    logic                  skid_valid_next;
    logic                  res_hit_reg, res_hit_next;
    logic [COORD_BITS-1:0] res_x_reg, res_x_next;
    logic [COORD_BITS-1:0] res_y_reg, res_y_next;
    logic                  skid_hit_reg, skid_hit_next;
    logic [COORD_BITS-1:0] skid_x_reg, skid_x_next;
    logic [COORD_BITS-1:0] skid_y_reg, skid_y_next;
    logic                  tail_take;

    assign tail_take = en && div_ctl.valid;

    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_hit_next    = res_hit_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        skid_valid_next = skid_valid_reg;
        skid_hit_next   = skid_hit_reg;
        skid_x_next     = skid_x_reg;
        skid_y_next     = skid_y_reg;
        if (!res_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                res_valid_next  = 1'b1;
                res_hit_next    = skid_hit_reg;
                res_x_next      = skid_x_reg;
                res_y_next      = skid_y_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                res_valid_next = tail_take;
                res_hit_next   = div_ctl.hit;
                res_x_next     = fin_x;
                res_y_next     = fin_y;
            end
        end
        else if (tail_take)
        begin
            skid_valid_next = 1'b1;
            skid_hit_next   = div_ctl.hit;
            skid_x_next     = fin_x;
            skid_y_next     = fin_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_hit_reg  <= res_hit_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        skid_hit_reg <= skid_hit_next;
        skid_x_reg   <= skid_x_next;
        skid_y_reg   <= skid_y_next;
    end

    assign result_valid = res_valid_reg;
    assign hit          = res_hit_reg;
    assign hit_x        = res_x_reg;
    assign hit_y        = res_y_reg;

    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid entry without a held result");

    a_hit_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_ctl_reg.valid && s4_ctl_reg.hit) |->
            (s4_dabs_reg != '0 && s4_n2abs_reg <= s4_dabs_reg))
        else $error("hit with out-of-range numerator");

    a_miss_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !hit) |-> (hit_x == '0 && hit_y == '0))
        else $error("miss with nonzero point");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(skid_valid_reg) |-> $past(res_valid_reg && !result_stall))
        else $error("skid entry dropped");

endmodule

>>> sv/sgi_div_pipe.sv
module sgi_div_pipe
    import sgi_pkg::*;
#(
    parameter int QUO_BITS     = COORD_BITS_DEF,
    parameter int DIVISOR_BITS = 2 * COORD_BITS_DEF + 2,
    parameter int REM_BITS     = 3 * COORD_BITS_DEF + 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  sgi_ctl_t                in_ctl,
    input  logic [DIVISOR_BITS-1:0] divisor,
    input  logic [REM_BITS-1:0]     dividend_x,
    input  logic [REM_BITS-1:0]     dividend_y,
    output sgi_ctl_t                out_ctl,
    output logic [QUO_BITS-1:0]     quo_x,
    output logic [QUO_BITS-1:0]     quo_y
);

    sgi_ctl_t                ctl_reg   [QUO_BITS];
    logic [DIVISOR_BITS-1:0] div_reg   [QUO_BITS];
    logic [REM_BITS-1:0]     rem_x_reg [QUO_BITS];
    logic [REM_BITS-1:0]     rem_y_reg [QUO_BITS];
    logic [QUO_BITS-1:0]     quo_x_reg [QUO_BITS];
    logic [QUO_BITS-1:0]     quo_y_reg [QUO_BITS];

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_stage
        localparam int B = QUO_BITS - 1 - k;

        sgi_ctl_t                ctl_prev;
        logic [DIVISOR_BITS-1:0] div_prev;
        logic [REM_BITS-1:0]     rem_x_prev;
        logic [REM_BITS-1:0]     rem_y_prev;
        logic [QUO_BITS-1:0]     quo_x_prev;
        logic [QUO_BITS-1:0]     quo_y_prev;
        logic [REM_BITS-1:0]     trial;
        logic [REM_BITS-1:0]     rem_x_next;
        logic [REM_BITS-1:0]     rem_y_next;
        logic [QUO_BITS-1:0]     quo_x_next;
        logic [QUO_BITS-1:0]     quo_y_next;

        if (k == 0)
        begin : g_first
            assign ctl_prev   = in_ctl;
            assign div_prev   = divisor;
            assign rem_x_prev = dividend_x;
            assign rem_y_prev = dividend_y;
            assign quo_x_prev = '0;
            assign quo_y_prev = '0;
        end
        else
        begin : g_next
            assign ctl_prev   = ctl_reg[k-1];
            assign div_prev   = div_reg[k-1];
            assign rem_x_prev = rem_x_reg[k-1];
            assign rem_y_prev = rem_y_reg[k-1];
            assign quo_x_prev = quo_x_reg[k-1];
            assign quo_y_prev = quo_y_reg[k-1];
        end

        assign trial = REM_BITS'(div_prev) << B;

        always_comb
        begin
            rem_x_next = rem_x_prev;
            rem_y_next = rem_y_prev;
            quo_x_next = quo_x_prev;
            quo_y_next = quo_y_prev;
            if (rem_x_prev >= trial)
            begin
                rem_x_next    = rem_x_prev - trial;
                quo_x_next[B] = 1'b1;
            end
            if (rem_y_prev >= trial)
            begin
                rem_y_next    = rem_y_prev - trial;
                quo_y_next[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (en)
            begin
                ctl_reg[k] <= ctl_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[k]   <= div_prev;
                rem_x_reg[k] <= rem_x_next;
                rem_y_reg[k] <= rem_y_next;
                quo_x_reg[k] <= quo_x_next;
                quo_y_reg[k] <= quo_y_next;
            end
        end
    end

    assign out_ctl = ctl_reg[QUO_BITS-1];
    assign quo_x   = quo_x_reg[QUO_BITS-1];
    assign quo_y   = quo_y_reg[QUO_BITS-1];

    a_rem_x_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ctl.valid && out_ctl.hit) |->
            (rem_x_reg[QUO_BITS-1] < REM_BITS'(div_reg[QUO_BITS-1])))
        else $error("x quotient too small on a hit");

    a_rem_y_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ctl.valid && out_ctl.hit) |->
            (rem_y_reg[QUO_BITS-1] < REM_BITS'(div_reg[QUO_BITS-1])))
        else $error("y quotient too small on a hit");

    a_hold_when_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(out_ctl) && $stable(quo_x) && $stable(quo_y)))
        else $error("divider moved while frozen");

endmodule
